FILE: design/rlm_pkg.sv
// Shared widths and types of the RMS level meter.
// No dependencies; every other design file but rlm_div imports this package.
package rlm_pkg;

  // Width of the per-buffer sum of squared samples.
  localparam int SUM_W = 56;
  // Width of twice the sum, the dividend of the mean-square division.
  localparam int DVD_W = SUM_W + 1;
  // Even width that holds the square-root operand.
  localparam int RT_W  = DVD_W + 1;
  // Width of a level value.
  localparam int LVL_W = 16;

  // Fill status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: design/rms_level_meter_window_avg.sv
// RMS level meter with a moving average over the last WINDOW_LEN buffer levels.
// Instantiates rlm_front, rlm_queue and rlm_back; depends on rlm_pkg.
//
// Usage: signed samples arrive on the in_ channel, one transfer per sample, with
// in_last marking the final sample of a capture buffer. Samples are squared and
// accumulated at one transfer per cycle. For each buffer one result transfer
// leaves on the out_ channel: out_level is the newest buffer level
// floor(sqrt(floor(2*sum/count))) while the level window still holds a zero,
// and the window average (out_averaged high) once every entry is nonzero.
// From the last sample of a buffer, its total passes the square register and
// the queue to the back part, then the iterative divider (one quotient bit a
// cycle), the square root (two operand bits a cycle), the window update, the
// average step when the average is taken, and the output register. The back
// part finishes one buffer before it takes the next from the queue. A two-entry
// queue holds buffer totals between the accumulator and the back part, so
// samples keep flowing at one per cycle while earlier buffers are finished;
// input stalls only while a last sample waits for room in the full queue, so a
// steady stream of buffers shorter than the back part's work sees in_stall.
// Reset clears the accumulator, the queue, the level window (through a fill
// count) and the output valid flag. When the receiver stalls, the result holds
// on out_ and the back part waits with its next result finished.
module rms_level_meter_window_avg import rlm_pkg::*; #(
  parameter int WINDOW_LEN         = 20,
  parameter int MAX_BUFFER_SAMPLES = 33554432,
  parameter int SAMPLE_BITS        = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [LVL_W-1:0]              out_level,
  output logic                          out_averaged
);

  // Sample count width; the count saturates at MAX_BUFFER_SAMPLES.
  localparam int CW = $clog2(MAX_BUFFER_SAMPLES + 1);

  q_stat_t              q_stat;
  logic                 q_push, q_pop;
  logic [SUM_W+CW-1:0]  q_wdata, q_rdata;

  rlm_front #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES),
    .CW                 (CW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  rlm_queue #(
    .DW (SUM_W + CW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  rlm_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .CW         (CW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .out_averaged (out_averaged)
  );

endmodule

FILE: design/rlm_front.sv
// Front part of the RMS level meter: squares samples and accumulates them per buffer.
// Depends on rlm_pkg; pushes finished buffer totals into rlm_queue.
module rlm_front import rlm_pkg::*; #(
  parameter int SAMPLE_BITS        = 16,
  parameter int MAX_BUFFER_SAMPLES = 33554432,
  parameter int CW                 = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  input  q_stat_t                       q_stat,
  output logic                          q_push,
  output logic [SUM_W+CW-1:0]           q_data
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_r;
  logic                   s1_last_r;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt, sum_upd;
  logic [CW-1:0]          cnt_r, cnt_nxt, cnt_upd;
  logic [SUM_W:0]         sum_ext;
  logic                   accept, advance;

  // Magnitude of the two's complement sample; the most negative code maps to 2^(N-1).
  assign mag = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;

  assign advance  = s1_valid_r & (~s1_last_r | ~q_stat.full);
  assign in_stall = s1_valid_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  assign s1_valid_nxt = accept | (s1_valid_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r      <= mag * mag;
      s1_last_r <= in_last;
    end
  end

  // Saturating accumulation; the count stops at the buffer limit.
  always_comb begin
    sum_ext = {1'b0, sum_r} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_r};
    sum_upd = sum_r;
    cnt_upd = cnt_r;
    if (cnt_r < CW'(MAX_BUFFER_SAMPLES)) begin
      sum_upd = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      cnt_upd = cnt_r + 1'b1;
    end
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (advance) begin
      if (s1_last_r) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
      end
    end
  end

  assign q_push = advance & s1_last_r;
  assign q_data = {sum_upd, cnt_upd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/rlm_queue.sv
// Two-entry queue that carries buffer totals from the front part to the back part.
// Depends on rlm_pkg for the status struct.
module rlm_queue import rlm_pkg::*; #(
  parameter int DW = 82
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output q_stat_t       stat
);

  logic [DW-1:0] ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("queue pop while empty");
`endif

endmodule

FILE: design/rlm_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing; used for the mean-square division by the sample count.
module rlm_div #(
  parameter int DVD_W = 57,
  parameter int DVS_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int NW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [NW-1:0]    n_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      n_r    <= NW'(DVD_W);
    end else if (busy_r) begin
      n_r    <= n_r - 1'b1;
      busy_r <= (n_r != NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
`endif

endmodule

FILE: design/rlm_back.sv
// Back part of the RMS level meter: mean square, square root, level window and output register.
// Depends on rlm_pkg and rlm_div; takes buffer totals from rlm_queue.
module rlm_back import rlm_pkg::*; #(
  parameter int WINDOW_LEN = 20,
  parameter int CW         = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  q_stat_t              q_stat,
  input  logic [SUM_W+CW-1:0]  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LVL_W-1:0]     out_level,
  output logic                 out_averaged
);

  localparam int DVS_W = (CW > 7) ? CW : 7;
  localparam int PW    = $clog2(WINDOW_LEN);
  localparam int FW    = $clog2(WINDOW_LEN + 1);
  localparam int TOT_W = LVL_W + $clog2(WINDOW_LEN);
  localparam logic [RT_W-1:0] SQ_TOP = RT_W'(1) << (RT_W - 2);
  // Reciprocal of the window length, exact for every total of TOT_W bits.
  localparam int RCP_K = TOT_W + $clog2(WINDOW_LEN);
  localparam int RCP_W = TOT_W + 1;
  localparam int PR_W  = TOT_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SQRT = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_AVG  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic              div_start, div_busy;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [DVS_W-1:0]  div_dvs;
  logic [RT_W-1:0]   v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt, t_sum;
  logic [LVL_W-1:0]  win_mem [WINDOW_LEN];
  logic [LVL_W-1:0]  rd_r, oldest, lvl;
  logic              mem_we;
  logic [PW-1:0]     ptr_r, ptr_nxt;
  logic [FW-1:0]     fill_r, fill_nxt, zeros_r, zeros_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [PR_W-1:0]   avg_prod;
  logic [LVL_W-1:0]  res_lvl_r, res_lvl_nxt;
  logic              res_avg_r, res_avg_nxt;
  logic              out_valid_r, out_valid_nxt, out_load;
  logic [LVL_W-1:0]  out_level_r;
  logic              out_avg_r;

  rlm_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign lvl    = res_r[LVL_W-1:0];
  assign oldest = (fill_r == FW'(WINDOW_LEN)) ? rd_r : '0;
  assign t_sum  = res_r + bit_r;
  // Window average: the registered total times the reciprocal, shifted down.
  assign avg_prod = PR_W'(total_r) * PR_W'(RCP_M);

  always_comb begin
    state_nxt   = state_r;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    div_dvd     = {q_data[SUM_W+CW-1:CW], 1'b0};
    div_dvs     = DVS_W'(q_data[CW-1:0]);
    v_nxt       = v_r;
    res_nxt     = res_r;
    bit_nxt     = bit_r;
    mem_we      = 1'b0;
    ptr_nxt     = ptr_r;
    fill_nxt    = fill_r;
    zeros_nxt   = zeros_r;
    total_nxt   = total_r;
    res_lvl_nxt = res_lvl_r;
    res_avg_nxt = res_avg_r;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          v_nxt     = {1'b0, div_quo};
          res_nxt   = '0;
          bit_nxt   = SQ_TOP;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_r == '0) begin
          state_nxt = ST_UPD;
        end else begin
          if (v_r >= t_sum) begin
            v_nxt   = v_r - t_sum;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      ST_UPD: begin
        mem_we    = 1'b1;
        ptr_nxt   = (ptr_r == PW'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
        if (fill_r != FW'(WINDOW_LEN)) begin
          fill_nxt = fill_r + 1'b1;
        end
        total_nxt = total_r - TOT_W'(oldest) + TOT_W'(lvl);
        zeros_nxt = zeros_r - FW'((oldest == '0) && (zeros_r != '0))
                    + FW'(lvl == '0);
        if (zeros_nxt != '0) begin
          res_lvl_nxt = lvl;
          res_avg_nxt = 1'b0;
          state_nxt   = ST_OUT;
        end else begin
          state_nxt   = ST_AVG;
        end
      end
      ST_AVG: begin
        res_lvl_nxt = avg_prod[RCP_K +: LVL_W];
        res_avg_nxt = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      fill_r      <= '0;
      zeros_r     <= FW'(WINDOW_LEN);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      zeros_r     <= zeros_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    res_lvl_r <= res_lvl_nxt;
    res_avg_r <= res_avg_nxt;
    if (out_load) begin
      out_level_r <= res_lvl_r;
      out_avg_r   <= res_avg_r;
    end
  end

  // Window store: written at the oldest slot, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[ptr_r] <= lvl;
    end
    rd_r <= win_mem[ptr_r];
  end

  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;
  assign out_averaged = out_avg_r;

endmodule
